/* hdl/midpoint_line_rasterizer_assert.svh */
// Assertion macros for the midpoint line rasterizer checker.
// Depends on nothing; included by the checker file.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Concurrent check that is switched off while reset is asserted.
`define MLR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("midpoint line rasterizer check failed");

// Concurrent check that also holds across reset.
`define MLR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("midpoint line rasterizer reset check failed");

`endif

/* hdl/mlr_pkg.sv */
// Shared types and constants of the midpoint line rasterizer.
// Depends on nothing; used by every module of the block.
package mlr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DEC_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } mlr_in_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        logic   last;
    } mlr_out_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t major_pos;
        coord_t minor_pos;
        coord_t major_end;
        dec_t   decision;
        dec_t   inc_straight;
        dec_t   inc_diagonal;
        logic   mirror_y;
        logic   swap_axes;
    } mlr_job_t;

endpackage

/* hdl/mlr_front.sv */
// Front end: classifies a request and, for a start, sets up the line.
// Depends on mlr_pkg.
module mlr_front (
    input  mlr_pkg::mlr_in_t  req,
    output mlr_pkg::mlr_job_t job
);
    import mlr_pkg::*;

    function automatic coord_t sat_coord(input coord_t v);
        coord_t r;
        r = v;
        if (v == COORD_MIN) begin
            r = COORD_MIN + coord_t'(1);
        end
        return r;
    endfunction

    coord_t                       x1, y1, x2, y2, tmp;
    logic signed [DIFF_BITS-1:0]  dx, dy, dtmp;
    logic        [DIFF_BITS-1:0]  adx, ady;
    dec_t                         dxw, dyw;
    logic                         mirror, swap;

    always_comb begin
        tmp  = '0;
        dtmp = '0;
        x1 = sat_coord(req.x_start);
        y1 = sat_coord(req.y_start);
        x2 = sat_coord(req.x_end);
        y2 = sat_coord(req.y_end);
        dx = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
        dy = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};

        mirror = (dx[DIFF_BITS-1] && !dy[DIFF_BITS-1] && dy != '0)
              || (!dx[DIFF_BITS-1] && dx != '0 && dy[DIFF_BITS-1]);
        if (mirror) begin
            y1 = -y1;
            y2 = -y2;
            dy = -dy;
        end

        adx  = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        ady  = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        swap = adx < ady;
        if (swap) begin
            tmp  = x1; x1 = y1; y1 = tmp;
            tmp  = x2; x2 = y2; y2 = tmp;
            dtmp = dx; dx = dy; dy = dtmp;
        end

        if (x1 > x2) begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
            dx  = -dx;
            dy  = -dy;
        end

        dxw = {{2{dx[DIFF_BITS-1]}}, dx};
        dyw = {{2{dy[DIFF_BITS-1]}}, dy};

        job.cmd          = req.cmd;
        job.major_pos    = x1;
        job.minor_pos    = y1;
        job.major_end    = x2;
        job.decision     = dyw + dyw - dxw;
        job.inc_straight = dyw + dyw;
        job.inc_diagonal = (dyw - dxw) + (dyw - dxw);
        job.mirror_y     = mirror;
        job.swap_axes    = swap;
    end

endmodule

/* hdl/mlr_queue.sv */
// Short request queue between the front end and the stepping back end.
// Depends on mlr_pkg.
module mlr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mlr_pkg::mlr_job_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mlr_pkg::mlr_job_t head_data
);
    import mlr_pkg::*;

    mlr_job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]      count_reg, count_next;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] r;
        r = p + QPTR_BITS'(1);
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end
        return r;
    endfunction

    assign full       = count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_BITS + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/mlr_back.sv */
// Back end: holds the line state, steps it and registers the output pixel.
// Depends on mlr_pkg.
module mlr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  mlr_pkg::mlr_job_t head_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mlr_pkg::mlr_out_t m_data
);
    import mlr_pkg::*;

    function automatic mlr_out_t pixel(input coord_t major, input coord_t minor,
                                       input logic sw, input logic mir,
                                       input logic lst);
        mlr_out_t r;
        r.px   = sw ? minor : major;
        r.py   = sw ? major : minor;
        if (mir) begin
            r.py = -r.py;
        end
        r.last = lst;
        return r;
    endfunction

    logic     active_reg, active_next;
    coord_t   major_pos_reg, major_pos_next;
    coord_t   minor_pos_reg, minor_pos_next;
    coord_t   major_end_reg, major_end_next;
    dec_t     decision_reg, decision_next;
    dec_t     inc_straight_reg, inc_straight_next;
    dec_t     inc_diagonal_reg, inc_diagonal_next;
    logic     mirror_y_reg, mirror_y_next;
    logic     swap_axes_reg, swap_axes_next;
    logic     out_valid_reg, out_valid_next;
    mlr_out_t out_data_reg, out_data_next;
    logic     can_take, lst;

    assign can_take = !out_valid_reg || m_ready;
    assign pop      = head_valid && can_take;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        active_next       = active_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        mirror_y_next     = mirror_y_reg;
        swap_axes_next    = swap_axes_reg;
        out_valid_next    = can_take ? 1'b0 : out_valid_reg;
        out_data_next     = out_data_reg;
        lst               = 1'b0;

        if (pop) begin
            unique case (head_data.cmd)
                CMD_START: begin
                    lst               = head_data.major_pos == head_data.major_end;
                    major_pos_next    = head_data.major_pos;
                    minor_pos_next    = head_data.minor_pos;
                    major_end_next    = head_data.major_end;
                    decision_next     = head_data.decision;
                    inc_straight_next = head_data.inc_straight;
                    inc_diagonal_next = head_data.inc_diagonal;
                    mirror_y_next     = head_data.mirror_y;
                    swap_axes_next    = head_data.swap_axes;
                    active_next       = !lst;
                    out_valid_next    = 1'b1;
                    out_data_next     = pixel(head_data.major_pos, head_data.minor_pos,
                                              head_data.swap_axes, head_data.mirror_y, lst);
                end
                CMD_STEP: begin
                    if (active_reg) begin
                        if (decision_reg[DEC_BITS-1] || decision_reg == '0) begin
                            decision_next = decision_reg + inc_straight_reg;
                        end else begin
                            decision_next  = decision_reg + inc_diagonal_reg;
                            minor_pos_next = minor_pos_reg + coord_t'(1);
                        end
                        major_pos_next = major_pos_reg + coord_t'(1);
                        lst            = major_pos_next == major_end_reg;
                        active_next    = !lst;
                        out_valid_next = 1'b1;
                        out_data_next  = pixel(major_pos_next, minor_pos_next,
                                               swap_axes_reg, mirror_y_reg, lst);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        major_pos_reg    <= major_pos_next;
        minor_pos_reg    <= minor_pos_next;
        major_end_reg    <= major_end_next;
        decision_reg     <= decision_next;
        inc_straight_reg <= inc_straight_next;
        inc_diagonal_reg <= inc_diagonal_next;
        mirror_y_reg     <= mirror_y_next;
        swap_axes_reg    <= swap_axes_next;
        out_data_reg     <= out_data_next;
    end

endmodule

/* hdl/midpoint_line_rasterizer.sv */
// Midpoint line rasterizer top level: front end, request queue and back end.
// Depends on mlr_pkg, mlr_front, mlr_queue and mlr_back.
// The block takes one request per clock while s_ready is high and gives at most one pixel
// per clock. A start request sets up the line in the front end and gives the first pixel;
// each step request gives the next pixel, and a step with no line in progress gives nothing.
// A request is captured in a two-entry queue when it is accepted and moves into the output
// register once that register is empty or its pixel is being taken. While a pixel is held,
// up to two requests wait in the queue before s_ready drops; with the output taken every
// cycle the block keeps one pixel per clock.
module midpoint_line_rasterizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mlr_pkg::mlr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mlr_pkg::mlr_out_t m_data
);
    import mlr_pkg::*;

    mlr_job_t new_job;
    mlr_job_t head_job;
    logic     q_full;
    logic     q_pop;
    logic     head_valid;

    assign s_ready = !q_full;

    mlr_front u_front (
        .req (s_data),
        .job (new_job)
    );

    mlr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_data  (new_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_job)
    );

    mlr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* hdl/mlr_checker.sv */
// Port-level checks of the midpoint line rasterizer, bound to the top level.
// Depends on mlr_pkg and midpoint_line_rasterizer_assert.svh.
`include "midpoint_line_rasterizer_assert.svh"

module mlr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input mlr_pkg::mlr_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input mlr_pkg::mlr_out_t m_data
);
    import mlr_pkg::*;

    `MLR_ASSERT_ALWAYS(ast_reset_idle, aclk, !aresetn |=> !m_valid)
    `MLR_ASSERT(ast_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `MLR_ASSERT(ast_ready_follows, aclk, aresetn, $past(m_ready) |-> s_ready)
    `MLR_ASSERT(ast_px_range, aclk, aresetn, m_valid |-> m_data.px != COORD_MIN)
    `MLR_ASSERT(ast_py_range, aclk, aresetn, m_valid |-> m_data.py != COORD_MIN)

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);
